[rtl/core/awod_pkg.sv]
`default_nettype none
package awod_pkg;

  localparam int NUM_REGS    = 28;
  localparam int MASK_GROUPS = 4;
  localparam int GROUP_BITS  = 7;
  localparam int HEADER      = 2 * MASK_GROUPS;
  localparam int HDR_W       = (HEADER > 1) ? $clog2(HEADER) : 1;
  // registers covered by the presence mask
  localparam int SCAN_REGS   = (NUM_REGS < MASK_GROUPS * GROUP_BITS) ?
                               NUM_REGS : MASK_GROUPS * GROUP_BITS;
  localparam int REG_W       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CNT_W       = $clog2(NUM_REGS + 1);
  localparam int BC_W        = 6;
  localparam int BC_MAX      = 63;
  localparam int CFG_BYTES   = 2 * NUM_REGS;

  localparam logic [7:0] DEFAULT_WAIT = 8'd10;

  typedef enum logic [1:0] {
    ACT_DATA    = 2'd0,
    ACT_CONFIG  = 2'd1,
    ACT_MAP     = 2'd2,
    ACT_DEFAULT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] total;
    logic [REG_W-1:0] reg_idx;
  } scan_res_t;

  typedef struct packed {
    logic             en;
    logic [REG_W-1:0] idx;
    logic [4:0]       addr;
    logic [7:0]       data;
    logic [7:0]       dly;
  } slot_wr_t;

endpackage
`default_nettype wire

[rtl/core/awod_scan.sv]
`default_nettype none
// Walks the presence vector one register per cycle: counts present
// registers and picks the register number of the target ordinal.
module awod_scan (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [awod_pkg::SCAN_REGS-1:0] pres_i,
  input  wire logic [awod_pkg::CNT_W-1:0]     target_i,
  output awod_pkg::scan_res_t                 res_o
);
  import awod_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             found_q, found_d;
  logic [REG_W-1:0] r_q, r_d;
  logic [REG_W-1:0] reg_q, reg_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    found_d = found_q;
    r_d     = r_q;
    reg_d   = reg_q;
    cnt_d   = cnt_q;
    if (start_i) begin
      busy_d  = 1'b1;
      found_d = 1'b0;
      r_d     = '0;
      cnt_d   = '0;
    end else if (busy_q) begin
      if (pres_i[r_q]) begin
        if (cnt_q == target_i && !found_q) begin
          found_d = 1'b1;
          reg_d   = r_q;
        end
        cnt_d = cnt_q + 1'b1;
      end
      if (r_q == REG_W'(SCAN_REGS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        r_d = r_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      r_q     <= '0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      found_q <= found_d;
      r_q     <= r_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reg_q <= reg_d;
  end

  assign res_o.done    = done_q;
  assign res_o.total   = cnt_q;
  assign res_o.reg_idx = reg_q;

endmodule
`default_nettype wire

[rtl/core/awod_slots.sv]
`default_nettype none
// Write slot buffer and the emission run, one slot per cycle while the
// output is not stalled, into an output register.
module awod_slots (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  awod_pkg::slot_wr_t      wr_i,
  input  wire logic               emit_start_i,
  input  wire logic [1:0]         chip_i,
  output logic                    emit_done_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              sid_address_o,
  output logic [7:0]              reg_data_o,
  output logic [7:0]              wait_cycles_o,
  output logic                    skip_o,
  output logic                    last_o
);
  import awod_pkg::*;

  logic [4:0]       addr_q [NUM_REGS];
  logic [7:0]       data_q [NUM_REGS];
  logic [7:0]       dly_q  [NUM_REGS];
  logic [NUM_REGS-1:0] valid_q;

  logic             active_q;
  logic [REG_W-1:0] p_q;
  logic [1:0]       chip_q;
  logic             ov_q;
  logic [7:0]       oaddr_q, odata_q, odly_q;
  logic             oskip_q, olast_q;

  logic load;
  logic taken;

  assign taken = ov_q && !out_stall_i;
  assign load  = active_q && (!ov_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      active_q <= 1'b0;
      p_q      <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.idx] <= 1'b1;
      end
      if (emit_start_i) begin
        active_q <= 1'b1;
        p_q      <= '0;
      end else if (load) begin
        valid_q[p_q] <= 1'b0;
        if (p_q == REG_W'(NUM_REGS - 1)) begin
          active_q <= 1'b0;
        end else begin
          p_q <= p_q + 1'b1;
        end
      end
      if (load) begin
        ov_q <= 1'b1;
      end else if (taken) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      addr_q[wr_i.idx] <= wr_i.addr;
      data_q[wr_i.idx] <= wr_i.data;
      dly_q[wr_i.idx]  <= wr_i.dly;
    end
    if (emit_start_i) begin
      chip_q <= chip_i;
    end
    if (load) begin
      olast_q <= (p_q == REG_W'(NUM_REGS - 1));
      if (valid_q[p_q]) begin
        oaddr_q <= {1'b0, chip_q, addr_q[p_q]};
        odata_q <= data_q[p_q];
        odly_q  <= dly_q[p_q];
        oskip_q <= 1'b0;
      end else begin
        oaddr_q <= '0;
        odata_q <= '0;
        odly_q  <= '0;
        oskip_q <= 1'b1;
      end
    end
  end

  assign emit_done_o   = taken && olast_q;
  assign out_valid_o   = ov_q;
  assign sid_address_o = oaddr_q;
  assign reg_data_o    = odata_q;
  assign wait_cycles_o = odly_q;
  assign skip_o        = oskip_q;
  assign last_o        = olast_q;

endmodule
`default_nettype wire

[rtl/core/asid_write_ordered_decoder_core.sv]
`default_nettype none
// Config, map, restore and leading header bytes complete in idle without a scan.
// The last header byte and every later data byte stall the input while the
// presence scanner walks SCAN_REGS registers, one register a cycle.
// A completed message then emits NUM_REGS slots, one per cycle when the
// output is not stalled; no item is taken during the run.
// Reset: async, clears control, slot valid bits and restores default order.
module asid_write_ordered_decoder_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] action_i,
  input  wire logic [7:0] byte_value_i,
  input  wire logic [1:0] chip_i,
  input  wire logic       first_i,
  input  wire logic [4:0] entry_index_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      sid_address_o,
  output logic [7:0]      reg_data_o,
  output logic [7:0]      wait_cycles_o,
  output logic            skip_o,
  output logic            last_o
);
  import awod_pkg::*;

  state_e state_q, state_d;

  logic [4:0]       oslot_q [NUM_REGS];
  logic [4:0]       oslot_d [NUM_REGS];
  logic [7:0]       owait_q [NUM_REGS];
  logic [7:0]       owait_d [NUM_REGS];
  logic [4:0]       amap_q  [NUM_REGS];
  logic [GROUP_BITS-1:0] mask_q [HEADER];
  logic [GROUP_BITS-1:0] mask_d [HEADER];
  logic [BC_W-1:0]  bc_q, bc_d;
  logic [CNT_W-1:0] ord_q, ord_d;
  logic [7:0]       chigh_q, chigh_d;
  logic [7:0]       byte_q;
  logic [1:0]       chip_q;
  logic             hdr_q, hdr_d;

  logic [SCAN_REGS-1:0] pres_vec;
  logic [SCAN_REGS-1:0] hi_vec;
  scan_res_t            scan_res;
  slot_wr_t             slot_wr;
  logic                 scan_start;
  logic                 emit_start;
  logic                 emit_done;
  logic                 accept;

  action_e         act;
  logic [BC_W-1:0] bc_in;
  logic [CNT_W-1:0] ord_in;
  logic [8:0]      cyc;
  logic [4:0]      sel_slot;
  logic            data_ok;

  assign act    = action_e'(action_i);
  assign accept = in_valid_i && !in_stall_o;
  assign bc_in  = first_i ? '0 : bc_q;
  assign ord_in = first_i ? '0 : ord_q;
  // slot byte bit 6 adds 128 to the cycle count
  assign cyc    = {1'b0, chigh_q[6], 7'h00} + {1'b0, byte_value_i};
  assign sel_slot = oslot_q[ord_q[REG_W-1:0]];
  assign data_ok  = ord_q < scan_res.total;

  always_comb begin
    for (int j = 0; j < SCAN_REGS; j++) begin
      pres_vec[j] = mask_q[j / GROUP_BITS][j % GROUP_BITS];
      hi_vec[j]   = mask_q[MASK_GROUPS + j / GROUP_BITS][j % GROUP_BITS];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && act == ACT_DATA) begin
          if (bc_in >= BC_W'(HEADER) || bc_in == BC_W'(HEADER - 1)) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          if (hdr_q) begin
            state_d = (scan_res.total == '0) ? ST_EMIT : ST_IDLE;
          end else if (data_ok && ord_q + 1'b1 == scan_res.total) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    scan_start = 1'b0;
    emit_start = 1'b0;
    slot_wr    = '0;
    oslot_d    = oslot_q;
    owait_d    = owait_q;
    mask_d     = mask_q;
    bc_d       = bc_q;
    ord_d      = ord_q;
    chigh_d    = chigh_q;
    hdr_d      = hdr_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_DATA: begin
              ord_d = ord_in;
              bc_d  = bc_in;
              if (bc_in < BC_W'(HEADER)) begin
                mask_d[bc_in[HDR_W-1:0]] = byte_value_i[GROUP_BITS-1:0];
                bc_d = bc_in + 1'b1;
                if (bc_in == BC_W'(HEADER - 1)) begin
                  scan_start = 1'b1;
                  hdr_d      = 1'b1;
                end
              end else begin
                scan_start = 1'b1;
                hdr_d      = 1'b0;
              end
            end
            ACT_CONFIG: begin
              bc_d = bc_in;
              if (bc_in < BC_W'(CFG_BYTES)) begin
                if (!bc_in[0]) begin
                  chigh_d = byte_value_i;
                end else begin
                  oslot_d[bc_in[REG_W:1]] = chigh_q[4:0];
                  if (cyc == '0) begin
                    owait_d[bc_in[REG_W:1]] = 8'd1;
                  end else if (cyc[8]) begin
                    owait_d[bc_in[REG_W:1]] = 8'hff;
                  end else begin
                    owait_d[bc_in[REG_W:1]] = cyc[7:0];
                  end
                end
                bc_d = bc_in + 1'b1;
              end
            end
            ACT_DEFAULT: begin
              for (int i = 0; i < NUM_REGS; i++) begin
                oslot_d[i] = 5'(i);
                owait_d[i] = DEFAULT_WAIT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          if (hdr_q) begin
            emit_start = (scan_res.total == '0);
          end else if (data_ok) begin
            slot_wr.en   = ({1'b0, sel_slot} < 6'(NUM_REGS));
            slot_wr.idx  = sel_slot[REG_W-1:0];
            slot_wr.addr = amap_q[scan_res.reg_idx];
            slot_wr.data = {hi_vec[scan_res.reg_idx], byte_q[6:0]};
            slot_wr.dly  = owait_q[ord_q[REG_W-1:0]];
            ord_d        = ord_q + 1'b1;
            if (bc_q < BC_W'(BC_MAX)) begin
              bc_d = bc_q + 1'b1;
            end
            emit_start = (ord_q + 1'b1 == scan_res.total);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bc_q    <= '0;
      ord_q   <= '0;
      chigh_q <= '0;
      hdr_q   <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        oslot_q[i] <= 5'(i);
        owait_q[i] <= DEFAULT_WAIT;
      end
      for (int g = 0; g < HEADER; g++) begin
        mask_q[g] <= '0;
      end
    end else begin
      state_q <= state_d;
      bc_q    <= bc_d;
      ord_q   <= ord_d;
      chigh_q <= chigh_d;
      hdr_q   <= hdr_d;
      oslot_q <= oslot_d;
      owait_q <= owait_d;
      mask_q  <= mask_d;
    end
  end

  // address map holds garbage until loaded
  always_ff @(posedge clk_i) begin
    if (accept && act == ACT_MAP && {1'b0, entry_index_i} < 6'(NUM_REGS)) begin
      amap_q[entry_index_i[REG_W-1:0]] <= byte_value_i[4:0];
    end
    if (accept && act == ACT_DATA) begin
      byte_q <= byte_value_i;
      chip_q <= chip_i;
    end
  end

  awod_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .pres_i   (pres_vec),
    .target_i (ord_d),
    .res_o    (scan_res)
  );

  awod_slots u_slots (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (slot_wr),
    .emit_start_i  (emit_start),
    .chip_i        (chip_q),
    .emit_done_o   (emit_done),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sid_address_o (sid_address_o),
    .reg_data_o    (reg_data_o),
    .wait_cycles_o (wait_cycles_o),
    .skip_o        (skip_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire
